// ===== rtl/core/mlp_pkg.sv =====
// shared types, constants and sigmoid table for the mlp inference block
package mlp_pkg;

    localparam int MAX_LAYERS = 4;
    localparam int MAX_WIDTH  = 16;
    localparam int WMEM_DEPTH = (MAX_LAYERS - 1) * (MAX_WIDTH + 1) * MAX_WIDTH;
    localparam int WADDR_W    = $clog2(WMEM_DEPTH);
    localparam int AMEM_DEPTH = 2 * MAX_WIDTH;
    localparam int AADDR_W    = $clog2(AMEM_DEPTH);
    localparam int ONE_Q12    = 4096;

    // opcodes of an input beat
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] CFG_WIDTH0      = 3'd1;
    localparam logic [2:0] CFG_WIDTH1      = 3'd2;
    localparam logic [2:0] CFG_WIDTH2      = 3'd3;
    localparam logic [2:0] CFG_WIDTH3      = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_ACT
    } t_state;

    typedef logic [255:0][12:0] t_sig_tab;

    // unsigned long division by shift and subtract, elaboration only
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid at bin centers, built at elaboration
    function automatic t_sig_tab f_sig_table();
        t_sig_tab    tab;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] v;
        tab = '0;
        p   = 64'd4162825044;
        for (int j = 0; j < 128; j++) begin
            d = 64'd4294967296 + p;
            v = f_udiv((64'd1 << 44) + (d >> 1), d);
            tab[128 + j] = v[12:0];
            tab[127 - j] = 13'(64'(ONE_Q12) - v);
            p = (p * 64'd4162825044) >> 32;
            p = (p * 64'd4162825044) >> 32;
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = f_sig_table();

endpackage

// ===== rtl/core/mlp_in_if.sv =====
// input channel: weight loads and samples
interface mlp_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [1:0]         weight_layer;
    logic [4:0]         weight_source;
    logic [3:0]         weight_dest;
    logic signed [15:0] weight_value;
    logic [3:0]         sample_index;
    logic signed [15:0] sample_value;
    logic               sample_last;

    modport source (output valid, opcode, weight_layer, weight_source, weight_dest,
                    weight_value, sample_index, sample_value, sample_last,
                    input ready);
    modport sink (input valid, opcode, weight_layer, weight_source, weight_dest,
                  weight_value, sample_index, sample_value, sample_last,
                  output ready);
endinterface

// ===== rtl/core/mlp_out_if.sv =====
// output channel: one activation of the output layer per beat
interface mlp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  output_index;
    logic [12:0] output_value;
    logic        output_last;

    modport source (output valid, output_index, output_value, output_last, input ready);
    modport sink (input valid, output_index, output_value, output_last, output ready);
endinterface

// ===== rtl/core/mlp_ram.sv =====
// generic simple dual port ram with registered read
module mlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/mlp_sigmoid_inference_top.sv =====
// forward pass of a small fully connected sigmoid network on one shared mac
//
// Input channel i_in: opcode 0 beats write one Q4.12 weight into weight
// memory, opcode 1 beats store one input sample. A sample beat with
// sample_last starts the forward pass; i_in.ready stays low until the pass
// has handed its last result to the output register.
// Output channel o_out: one beat per output neuron, in neuron order, with
// output_last on the final one.
// Weight beats and plain sample beats are taken whenever the block is idle.
// A run takes, per neuron of layers 1 and up, (previous width + 1) mac
// terms followed by pipeline drain and activation; the single multiplier
// and the one read port of weight memory set the length of a run.
// A stalled receiver holds the output register; the pass waits at the next
// output neuron until the register frees, so no result is lost.
// Reset restores the configuration defaults, clears the input store and the
// control state; weight memory keeps whatever it holds and must be loaded
// before use. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data.
module mlp_sigmoid_inference_top
    import mlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlp_in_if.sink    i_in,
    mlp_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [4:0] i_cfg_data
);
    // configuration registers
    logic [2:0] r_lcnt;
    logic [4:0] r_w0, r_w1, r_w2, r_w3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt <= 3'd3;
            r_w0   <= 5'd16;
            r_w1   <= 5'd16;
            r_w2   <= 5'd16;
            r_w3   <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LAYER_COUNT: r_lcnt <= i_cfg_data[2:0];
                CFG_WIDTH0:      r_w0   <= i_cfg_data;
                CFG_WIDTH1:      r_w1   <= i_cfg_data;
                CFG_WIDTH2:      r_w2   <= i_cfg_data;
                CFG_WIDTH3:      r_w3   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [4:0] f_clamp_w(input logic [4:0] w);
        logic [4:0] r;
        r = w;
        if (w == 5'd0) r = 5'd1;
        if (w > 5'd16) r = 5'd16;
        return r;
    endfunction

    // effective layer count and last layer index
    logic [1:0] last_layer;
    always_comb begin
        if (r_lcnt < 3'd2)      last_layer = 2'd1;
        else if (r_lcnt > 3'd4) last_layer = 2'd3;
        else                    last_layer = 2'(r_lcnt - 3'd1);
    end

    t_state     r_st, n_st;
    logic [1:0] r_layer, n_layer;
    logic [3:0] r_n, n_n;
    logic [4:0] r_s, n_s;
    logic       r_issue, n_issue;
    logic [4:0] wprev, wcur;

    always_comb begin
        case (r_layer)
            2'd1:    begin wprev = f_clamp_w(r_w0); wcur = f_clamp_w(r_w1); end
            2'd2:    begin wprev = f_clamp_w(r_w1); wcur = f_clamp_w(r_w2); end
            2'd3:    begin wprev = f_clamp_w(r_w2); wcur = f_clamp_w(r_w3); end
            default: begin wprev = f_clamp_w(r_w0); wcur = f_clamp_w(r_w1); end
        endcase
    end

    logic in_acc;
    assign i_in.ready = (r_st == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // input store, cleared after each run
    logic signed [15:0] r_inst [MAX_WIDTH];
    logic               clr_inst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_inst) begin
            for (int k = 0; k < MAX_WIDTH; k++) r_inst[k] <= '0;
        end else if (in_acc && i_in.opcode == OP_SAMPLE) begin
            r_inst[i_in.sample_index] <= i_in.sample_value;
        end
    end

    // weight memory
    logic               w_we;
    logic [WADDR_W-1:0] w_waddr, w_raddr;
    logic [15:0]        w_rdata;
    logic [1:0]         lm1;

    assign w_we    = in_acc && i_in.opcode == OP_WEIGHT && i_in.weight_layer <= 2'd2
                     && i_in.weight_source <= 5'd16;
    assign w_waddr = WADDR_W'(i_in.weight_layer) * WADDR_W'(272)
                     + WADDR_W'({i_in.weight_source, 4'b0}) + WADDR_W'(i_in.weight_dest);
    assign lm1     = r_layer - 2'd1;
    assign w_raddr = WADDR_W'(lm1) * WADDR_W'(272) + WADDR_W'({r_s, 4'b0}) + WADDR_W'(r_n);

    mlp_ram #(.WIDTH(16), .DEPTH(WMEM_DEPTH)) u_wmem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.weight_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // activation memory, two banks selected by layer parity
    logic               a_we;
    logic [AADDR_W-1:0] a_waddr, a_raddr;
    logic [15:0]        a_wdata, a_rdata;

    assign a_raddr = {~r_layer[0], r_s[3:0]};
    assign a_waddr = {r_layer[0], r_n};

    mlp_ram #(.WIDTH(16), .DEPTH(AMEM_DEPTH)) u_amem (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    // mac pipeline: issue, multiply, accumulate
    logic               r_p1v, r_b1, r_l1, r_src_in1;
    logic signed [15:0] r_in1;
    logic               r_p2v, r_l2;
    logic signed [31:0] r_prod;
    logic signed [31:0] r_acc;
    logic signed [15:0] mul_a;
    logic signed [32:0] sum33;
    logic signed [31:0] sum_sat;
    logic               acc_clr;

    always_comb begin
        if (r_b1)           mul_a = 16'(ONE_Q12);
        else if (r_src_in1) mul_a = r_in1;
        else                mul_a = a_rdata;
    end

    assign sum33 = {r_acc[31], r_acc} + {r_prod[31], r_prod};
    always_comb begin
        if (sum33[32] != sum33[31]) sum_sat = sum33[32] ? 32'sh80000000 : 32'sh7fffffff;
        else                        sum_sat = sum33[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
        end else begin
            r_p1v <= r_issue;
            r_p2v <= r_p1v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1      <= (r_s == wprev);
        r_l1      <= (r_s == wprev);
        r_src_in1 <= (r_layer == 2'd1);
        r_in1     <= r_inst[r_s[3:0]];
        r_prod    <= mul_a * $signed(w_rdata);
        r_l2      <= r_l1;
        if (acc_clr)    r_acc <= '0;
        else if (r_p2v) r_acc <= sum_sat;
    end

    // clamp to [-8,8) and table lookup
    logic [7:0]  sig_idx;
    logic [12:0] sig_val;
    always_comb begin
        if (r_acc < -32'sd134217728)     sig_idx = 8'd0;
        else if (r_acc > 32'sd134217727) sig_idx = 8'd255;
        else                             sig_idx = {~r_acc[27], r_acc[26:20]};
    end
    assign sig_val = SIG_TAB[sig_idx];
    assign a_wdata = {3'b0, sig_val};

    // output register
    logic        r_ov;
    logic [3:0]  r_oidx;
    logic [12:0] r_oval;
    logic        r_olast;
    logic        out_load, slot_free;

    assign slot_free = !r_ov || o_out.ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oidx  <= r_n;
            r_oval  <= sig_val;
            r_olast <= (5'(r_n) == wcur - 5'd1);
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.output_index = r_oidx;
    assign o_out.output_value = r_oval;
    assign o_out.output_last  = r_olast;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_layer <= 2'd1;
            r_n     <= '0;
            r_s     <= '0;
            r_issue <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_layer <= n_layer;
            r_n     <= n_n;
            r_s     <= n_s;
            r_issue <= n_issue;
        end
    end

    always_comb begin
        n_st     = r_st;
        n_layer  = r_layer;
        n_n      = r_n;
        n_s      = r_s;
        n_issue  = r_issue;
        acc_clr  = 1'b0;
        a_we     = 1'b0;
        out_load = 1'b0;
        clr_inst = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (in_acc && i_in.opcode == OP_SAMPLE && i_in.sample_last) begin
                    n_st    = S_MAC;
                    n_layer = 2'd1;
                    n_n     = '0;
                    n_s     = '0;
                    n_issue = 1'b1;
                    acc_clr = 1'b1;
                end
            end
            S_MAC: begin
                if (r_issue) begin
                    n_s = r_s + 5'd1;
                    if (r_s == wprev) n_issue = 1'b0;
                end
                if (r_p2v && r_l2) n_st = S_ACT;
            end
            S_ACT: begin
                if (r_layer != last_layer) begin
                    a_we    = 1'b1;
                    n_st    = S_MAC;
                    n_s     = '0;
                    n_issue = 1'b1;
                    acc_clr = 1'b1;
                    if (5'(r_n) == wcur - 5'd1) begin
                        n_n     = '0;
                        n_layer = r_layer + 2'd1;
                    end else begin
                        n_n = r_n + 4'd1;
                    end
                end else if (slot_free) begin
                    out_load = 1'b1;
                    if (5'(r_n) == wcur - 5'd1) begin
                        n_st     = S_IDLE;
                        clr_inst = 1'b1;
                    end else begin
                        n_st    = S_MAC;
                        n_n     = r_n + 4'd1;
                        n_s     = '0;
                        n_issue = 1'b1;
                        acc_clr = 1'b1;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_oval <= 13'd4096)
        else $error("activation above one");
    a_pipe_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1v || r_p2v) |-> r_st == S_MAC)
        else $error("mac pipeline busy outside mac phase");
    a_wmem_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_st == S_IDLE)
        else $error("weight write during a run");
    a_act_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_we |-> !out_load && r_layer != last_layer)
        else $error("output layer written to activation memory");
`endif

endmodule
